>>> rtl/esc_pkg.sv
package esc_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] REG_TEMP_CALIB       = 3'd0;
  localparam logic [2:0] REG_PRESS_CALIB_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_CALIB_MID  = 3'd2;
  localparam logic [2:0] REG_PRESS_CALIB_HIGH = 3'd3;
  localparam logic [2:0] REG_HUM_CALIB_LOW    = 3'd4;
  localparam logic [2:0] REG_HUM_CALIB_HIGH   = 3'd5;

  typedef struct packed {
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    logic [15:0] adc_humidity;
  } esc_frame_t;

  typedef struct packed {
    logic [47:0] temp_calib;
    logic [47:0] press_low;
    logic [47:0] press_mid;
    logic [47:0] press_high;
    logic [31:0] hum_low;
    logic [31:0] hum_high;
  } esc_calib_t;

  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] v, int s);
    return 64'($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx16(logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

>>> rtl/environmental_sensor_compensation.sv
// Integer compensation of one sensor frame: temperature, pressure, humidity.
// Input channel (in_valid/in_ready) carries one request with the three raw
// converter readings. A small queue takes requests whenever it has room, so
// the sender is not held while an earlier frame is being worked on.
// Result channel (out_valid/out_ready) returns temperature in 0.01 degC,
// pressure in Pa/256, humidity in %RH/1024 and a flag for a zero divisor.
// Configuration (cfg_valid/cfg_ready) writes one calibration register per
// request; cfg_ready is always high and indexes beyond the list are ignored.
// The engine runs up to 21 multiply steps on one shared 32x32 multiplier
// (the three pressure tail steps are skipped when the pressure divisor is
// zero), plus a restoring divider for the pressure term. The engine takes a
// new frame only once it is back in idle with the last one passed to its
// output register; that shared multiplier and the divider set the sustained
// rate. The finished result sits in an output register while the next frame
// is already dequeued and computed; when the receiver stalls, the engine
// waits with its result and the queue fills, then in_ready drops.
// Reset clears all calibration registers, the queue and the output valid.
module environmental_sensor_compensation import esc_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] in_adc_temperature,
  input  logic [19:0] in_adc_pressure,
  input  logic [15:0] in_adc_humidity,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_frac,
  output logic [16:0] out_humidity_frac,
  output logic        out_pressure_div_zero,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  esc_calib_t calib_r;
  esc_frame_t in_frame, deq_frame;
  logic       deq_valid, deq_ready;

  assign cfg_ready = 1'b1;

  // Calibration registers; the user must write them only while the block is idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_CALIB:       calib_r.temp_calib <= cfg_data;
        REG_PRESS_CALIB_LOW:  calib_r.press_low  <= cfg_data;
        REG_PRESS_CALIB_MID:  calib_r.press_mid  <= cfg_data;
        REG_PRESS_CALIB_HIGH: calib_r.press_high <= cfg_data;
        REG_HUM_CALIB_LOW:    calib_r.hum_low    <= cfg_data[31:0];
        REG_HUM_CALIB_HIGH:   calib_r.hum_high   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign in_frame.adc_temperature = in_adc_temperature;
  assign in_frame.adc_pressure    = in_adc_pressure;
  assign in_frame.adc_humidity    = in_adc_humidity;

  // Front: request queue.
  esc_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_frame  (in_frame),
    .deq_valid (deq_valid),
    .deq_ready (deq_ready),
    .deq_frame (deq_frame)
  );

  // Back: compensation engine with its output register.
  esc_engine u_engine (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .calib                 (calib_r),
    .deq_valid             (deq_valid),
    .deq_ready             (deq_ready),
    .deq_frame             (deq_frame),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_frac     (out_pressure_frac),
    .out_humidity_frac     (out_humidity_frac),
    .out_pressure_div_zero (out_pressure_div_zero)
  );

endmodule

>>> rtl/esc_queue.sv
module esc_queue import esc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  esc_frame_t in_frame,
  output logic       deq_valid,
  input  logic       deq_ready,
  output esc_frame_t deq_frame
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esc_frame_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push, pop;

  assign in_ready  = (cnt_r != CW'(DEPTH));
  assign deq_valid = (cnt_r != '0);
  assign deq_frame = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/esc_engine.sv
module esc_engine import esc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  esc_calib_t  calib,
  input  logic        deq_valid,
  output logic        deq_ready,
  input  esc_frame_t  deq_frame,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_temperature_centi,
  output logic [31:0] out_pressure_frac,
  output logic [16:0] out_humidity_frac,
  output logic        out_pressure_div_zero
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [4:0] OP_FIRST_PRESS_TAIL = 5'd10;
  localparam logic [4:0] OP_FIRST_HUM        = 5'd13;
  localparam logic [4:0] OP_LAST             = 5'd20;

  logic [1:0]  state_r;
  logic [4:0]  op_r;
  logic [1:0]  ph_r;
  logic [5:0]  div_cnt_r;
  esc_frame_t  fr_r;
  logic [63:0] acc_r;

  logic [31:0] v1_r, tmp_r, tf_r, hv_r, x_r, j_r, k_r, y_r, v_r, o_r;
  logic [63:0] w1_r, a_r, w2_r, c_r, dq_r, md_r, rem_r, q_r, g_r;
  logic [31:0] pr_r;
  logic        dz_r, qneg_r;
  logic [16:0] hum_r;

  logic        out_valid_r;
  logic [31:0] out_temp_r, out_pres_r;
  logic [16:0] out_hum_r;
  logic        out_dz_r;

  // Calibration fields.
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  always_comb begin
    t1 = {48'd0, calib.temp_calib[15:0]};
    t2 = sx16(calib.temp_calib[31:16]);
    t3 = sx16(calib.temp_calib[47:32]);
    p1 = {48'd0, calib.press_low[15:0]};
    p2 = sx16(calib.press_low[31:16]);
    p3 = sx16(calib.press_low[47:32]);
    p4 = sx16(calib.press_mid[15:0]);
    p5 = sx16(calib.press_mid[31:16]);
    p6 = sx16(calib.press_mid[47:32]);
    p7 = sx16(calib.press_high[15:0]);
    p8 = sx16(calib.press_high[31:16]);
    p9 = sx16(calib.press_high[47:32]);
    h1 = {24'd0, calib.hum_low[7:0]};
    h2 = {{16{calib.hum_low[23]}}, calib.hum_low[23:8]};
    h3 = {24'd0, calib.hum_low[31:24]};
    h4 = {{20{calib.hum_high[11]}}, calib.hum_high[11:0]};
    h5 = {{20{calib.hum_high[23]}}, calib.hum_high[23:12]};
    h6 = {{24{calib.hum_high[31]}}, calib.hum_high[31:24]};
  end

  logic [31:0] at32, ah32, p32;
  logic [63:0] ap64;
  logic [63:0] mul_a, mul_b, pp, acc_nxt;
  logic [31:0] pm_a, pm_b;

  assign at32 = {12'd0, fr_r.adc_temperature};
  assign ah32 = {16'd0, fr_r.adc_humidity};
  assign ap64 = {44'd0, fr_r.adc_pressure};
  assign p32  = acc_r[31:0];

  // Operand selection for the current step.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_r)
      5'd0: begin
        mul_a = sx32((at32 >> 3) - (t1[31:0] << 1));
        mul_b = t2;
      end
      5'd1: begin
        mul_a = sx32((at32 >> 4) - t1[31:0]);
        mul_b = sx32((at32 >> 4) - t1[31:0]);
      end
      5'd2:  begin mul_a = sx32(tmp_r); mul_b = t3; end
      5'd3:  begin mul_a = w1_r; mul_b = w1_r; end
      5'd4:  begin mul_a = a_r;  mul_b = p6; end
      5'd5:  begin mul_a = w1_r; mul_b = p5; end
      5'd6:  begin mul_a = a_r;  mul_b = p3; end
      5'd7:  begin mul_a = w1_r; mul_b = p2; end
      5'd8:  begin mul_a = c_r;  mul_b = p1; end
      5'd9: begin
        mul_a = ((64'd1048576 - ap64) << 31) - w2_r;
        mul_b = 64'd3125;
      end
      5'd10: begin mul_a = p9;   mul_b = asr64(q_r, 13); end
      5'd11: begin mul_a = g_r;  mul_b = asr64(q_r, 13); end
      5'd12: begin mul_a = p8;   mul_b = q_r; end
      5'd13: begin mul_a = sx32(h5); mul_b = sx32(hv_r); end
      5'd14: begin mul_a = sx32(hv_r); mul_b = sx32(h6); end
      5'd15: begin mul_a = sx32(hv_r); mul_b = sx32(h3); end
      5'd16: begin mul_a = sx32(j_r); mul_b = sx32(k_r); end
      5'd17: begin mul_a = sx32(y_r); mul_b = sx32(h2); end
      5'd18: begin mul_a = sx32(x_r); mul_b = sx32(y_r); end
      5'd19: begin mul_a = sx32(asr32(v_r, 15)); mul_b = sx32(asr32(v_r, 15)); end
      5'd20: begin mul_a = sx32(o_r); mul_b = sx32(h1); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Low 64 bits of the product, one 32x32 partial product in each of the first three phases.
  always_comb begin
    case (ph_r)
      2'd0:    begin pm_a = mul_a[31:0];  pm_b = mul_b[31:0];  end
      2'd1:    begin pm_a = mul_a[31:0];  pm_b = mul_b[63:32]; end
      default: begin pm_a = mul_a[63:32]; pm_b = mul_b[31:0];  end
    endcase
    pp = 64'(pm_a) * 64'(pm_b);
    if (ph_r == 2'd0) begin
      acc_nxt = pp;
    end else begin
      acc_nxt = acc_r + {pp[31:0], 32'd0};
    end
  end

  // Divider step on magnitudes.
  logic [64:0] rem_sh, diff;
  logic [63:0] dq_nxt, rem_nxt;
  always_comb begin
    rem_sh = {rem_r, dq_r[63]};
    diff   = rem_sh - {1'b0, md_r};
    if (!diff[64]) begin
      rem_nxt = diff[63:0];
      dq_nxt  = {dq_r[62:0], 1'b1};
    end else begin
      rem_nxt = rem_sh[63:0];
      dq_nxt  = {dq_r[62:0], 1'b0};
    end
  end

  logic [31:0] tf_nxt, vf, tsc;
  always_comb begin
    tf_nxt = v1_r + asr32(p32, 14);
    vf     = v_r - asr32(asr32(p32, 4), 0);
    tsc    = asr32((tf_r << 2) + tf_r + 32'd128, 8);
  end

  assign deq_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      op_r        <= '0;
      ph_r        <= '0;
      div_cnt_r   <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (deq_valid) begin
            fr_r    <= deq_frame;
            op_r    <= '0;
            ph_r    <= '0;
            dz_r    <= 1'b0;
            pr_r    <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (ph_r != 2'd3) begin
            acc_r <= acc_nxt;
            ph_r  <= ph_r + 1'b1;
          end else begin
            ph_r <= '0;
            op_r <= op_r + 1'b1;
            case (op_r)
              5'd0: v1_r  <= asr32(p32, 11);
              5'd1: tmp_r <= asr32(p32, 12);
              5'd2: begin
                tf_r <= tf_nxt;
                w1_r <= sx32(tf_nxt) - 64'd128000;
                hv_r <= tf_nxt - 32'd76800;
              end
              5'd3: a_r  <= acc_r;
              5'd4: w2_r <= acc_r;
              5'd5: w2_r <= w2_r + (acc_r << 17) + (p4 << 35);
              5'd6: c_r  <= asr64(acc_r, 8);
              5'd7: c_r  <= c_r + (acc_r << 12) + (64'd1 << 47);
              5'd8: c_r  <= asr64(acc_r, 33);
              5'd9: begin
                if (c_r == '0) begin
                  dz_r <= 1'b1;
                  op_r <= OP_FIRST_HUM;
                end else begin
                  dq_r      <= acc_r[63] ? 64'd0 - acc_r : acc_r;
                  md_r      <= c_r[63] ? 64'd0 - c_r : c_r;
                  qneg_r    <= acc_r[63] ^ c_r[63];
                  rem_r     <= '0;
                  div_cnt_r <= '0;
                  state_r   <= ST_DIV;
                end
              end
              5'd11: g_r <= asr64(acc_r, 25);
              5'd12: begin
                pr_r <= 32'(asr64(q_r + g_r + asr64(acc_r, 19), 8) + (p7 << 4));
              end
              5'd13: begin
                x_r <= asr32((ah32 << 14) - (h4 << 20) - p32 + 32'd16384, 15);
              end
              5'd14: j_r <= asr32(p32, 10);
              5'd15: k_r <= asr32(p32, 11) + 32'd32768;
              5'd16: y_r <= asr32(p32, 10) + 32'd2097152;
              5'd17: y_r <= asr32(p32 + 32'd8192, 14);
              5'd18: v_r <= p32;
              5'd19: o_r <= asr32(p32, 7);
              5'd20: begin
                if (vf[31]) begin
                  hum_r <= '0;
                end else if (vf > 32'd419430400) begin
                  hum_r <= 17'(32'd419430400 >> 12);
                end else begin
                  hum_r <= vf[28:12];
                end
                state_r <= ST_DONE;
              end
              default: g_r <= acc_r;
            endcase
            if (op_r == OP_LAST) begin
              op_r <= op_r;
            end
          end
        end
        ST_DIV: begin
          dq_r      <= dq_nxt;
          rem_r     <= rem_nxt;
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == 6'd63) begin
            q_r     <= qneg_r ? 64'd0 - dq_nxt : dq_nxt;
            op_r    <= OP_FIRST_PRESS_TAIL;
            ph_r    <= '0;
            state_r <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= tsc;
            out_pres_r  <= pr_r;
            out_hum_r   <= hum_r;
            out_dz_r    <= dz_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_frac     = out_pres_r;
  assign out_humidity_frac     = out_hum_r;
  assign out_pressure_div_zero = out_dz_r;

endmodule

>>> sim/tb_environmental_sensor_compensation.sv
module tb_environmental_sensor_compensation;
  timeunit 1ns;
  timeprecision 1ps;

  import esc_pkg::*;

  // Expected compensated reading for one accepted frame.
  typedef struct {
    logic [31:0] temperature;
    logic [31:0] pressure;
    logic [16:0] humidity;
    logic        div_zero;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [19:0] in_adc_temperature = '0;
  logic [19:0] in_adc_pressure = '0;
  logic [15:0] in_adc_humidity = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_temperature_centi;
  logic [31:0] out_pressure_frac;
  logic [16:0] out_humidity_frac;
  logic        out_pressure_div_zero;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;

  // Shadow copy of the calibration registers, updated on every accepted write.
  logic [47:0] calib [6];
  reading_t    pending_readings [$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_len = 0;
  int          stall_left = 0;

  environmental_sensor_compensation u_top (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // The run is ended here if the block ever stops making progress.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Arithmetic right shifts at the block's two internal widths.
  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int s);
    return $signed(v) >>> s;
  endfunction

  // Signed 64-bit divide truncating toward zero; the most negative dividend
  // over minus one wraps back to itself, as the magnitude path gives.
  function automatic logic [63:0] sdiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] ^ d[63]) ? -q : q;
  endfunction

  // Computes the compensated reading from the raw frame and the calibration
  // shadow. The fine temperature feeds both the pressure and humidity paths.
  function automatic reading_t compensate(logic [19:0] adc_t, logic [19:0] adc_p,
                                          logic [15:0] adc_h);
    reading_t    r;
    logic [31:0] at, ah, t1, t2, t3, a, b, d, v1, v2, fine;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, w1, w2, m, p, q1, q2;
    logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y, s, c, e;
    logic [47:0] tc, pl, pm, ph, hl, hh;

    tc = calib[REG_TEMP_CALIB];
    pl = calib[REG_PRESS_CALIB_LOW];
    pm = calib[REG_PRESS_CALIB_MID];
    ph = calib[REG_PRESS_CALIB_HIGH];
    hl = calib[REG_HUM_CALIB_LOW];
    hh = calib[REG_HUM_CALIB_HIGH];

    // Temperature, 32-bit wrapping arithmetic.
    at = {12'b0, adc_t};
    t1 = {16'b0, tc[15:0]};
    t2 = {{16{tc[31]}}, tc[31:16]};
    t3 = {{16{tc[47]}}, tc[47:32]};
    a = (at >> 3) - (t1 << 1);
    a = a * t2;
    v1 = sra32(a, 11);
    d = (at >> 4) - t1;
    b = d * d;
    b = sra32(b, 12);
    b = b * t3;
    v2 = sra32(b, 14);
    fine = v1 + v2;
    a = fine * 32'd5 + 32'd128;
    r.temperature = sra32(a, 8);

    // Pressure, 64-bit wrapping arithmetic.
    p1 = {48'b0, pl[15:0]};
    p2 = {{48{pl[31]}}, pl[31:16]};
    p3 = {{48{pl[47]}}, pl[47:32]};
    p4 = {{48{pm[15]}}, pm[15:0]};
    p5 = {{48{pm[31]}}, pm[31:16]};
    p6 = {{48{pm[47]}}, pm[47:32]};
    p7 = {{48{ph[15]}}, ph[15:0]};
    p8 = {{48{ph[31]}}, ph[31:16]};
    p9 = {{48{ph[47]}}, ph[47:32]};
    w1 = {{32{fine[31]}}, fine} - 64'd128000;
    w2 = w1 * w1 * p6;
    m = w1 * p5;
    w2 = w2 + (m << 17);
    w2 = w2 + (p4 << 35);
    m = w1 * w1 * p3;
    p = w1 * p2;
    w1 = sra64(m, 8) + (p << 12);
    m = ((64'd1 << 47) + w1) * p1;
    w1 = sra64(m, 33);
    r.pressure = '0;
    r.div_zero = 1'b0;
    if (w1 == 64'd0) begin
      r.div_zero = 1'b1;
    end else begin
      p = 64'd1048576 - {44'b0, adc_p};
      m = ((p << 31) - w2) * 64'd3125;
      p = sdiv64(m, w1);
      m = sra64(p, 13);
      m = p9 * m * m;
      q1 = sra64(m, 25);
      m = p8 * p;
      q2 = sra64(m, 19);
      m = p + q1 + q2;
      p = sra64(m, 8) + (p7 << 4);
      r.pressure = p[31:0];
    end

    // Humidity, 32-bit wrapping arithmetic with H4 and H5 as signed 12-bit.
    ah = {16'b0, adc_h};
    h1 = {24'b0, hl[7:0]};
    h2 = {{16{hl[23]}}, hl[23:8]};
    h3 = {24'b0, hl[31:24]};
    h4 = {{20{hh[11]}}, hh[11:0]};
    h5 = {{20{hh[23]}}, hh[23:12]};
    h6 = {{24{hh[31]}}, hh[31:24]};
    v = fine - 32'd76800;
    c = (ah << 14) - (h4 << 20) - h5 * v + 32'd16384;
    x = sra32(c, 15);
    c = v * h6;
    e = v * h3;
    c = sra32(c, 10) * (sra32(e, 11) + 32'd32768);
    y = sra32(c, 10) + 32'd2097152;
    c = y * h2 + 32'd8192;
    y = sra32(c, 14);
    v = x * y;
    s = sra32(v, 15);
    c = s * s;
    c = sra32(c, 7) * h1;
    v = v - sra32(c, 4);
    if (v[31])
      v = '0;
    else if (v > 32'd419430400)
      v = 32'd419430400;
    r.humidity = 17'(v >> 12);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Result checker. Outputs and out_ready are stable at the falling edge, so a
  // request seen here is the one taken at the next rising edge.
  always @(negedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected result", out_temperature_centi, '0);
      end else begin
        want = pending_readings.pop_front();
        if (out_temperature_centi !== want.temperature)
          report_mismatch("temperature", out_temperature_centi, want.temperature);
        if (out_pressure_frac !== want.pressure)
          report_mismatch("pressure", out_pressure_frac, want.pressure);
        if (out_humidity_frac !== want.humidity)
          report_mismatch("humidity", 32'(out_humidity_frac), 32'(want.humidity));
        if (out_pressure_div_zero !== want.div_zero)
          report_mismatch("div_zero", 32'(out_pressure_div_zero), 32'(want.div_zero));
      end
    end
  end

  // Receiver side. A long hold-off, when one is requested, is counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_len != 0) begin
      stall_left <= hold_len - 1;
      hold_len = 0;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Sends one frame request. Called and returning at a rising edge; in_valid is
  // left high so that back-to-back requests keep it high without a glitch.
  task automatic send_frame(logic [19:0] adc_t, logic [19:0] adc_p, logic [15:0] adc_h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_temperature <= adc_t;
    in_adc_pressure <= adc_p;
    in_adc_humidity <= adc_h;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_readings.push_back(compensate(adc_t, adc_p, adc_h));
  endtask

  // Stops sending and waits until every pending reading has been checked.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes one calibration register; only called while the block is idle.
  task automatic write_reg(logic [2:0] idx, logic [47:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_PRESS_CALIB_HIGH)
      calib[idx] = value;
    else if (idx <= REG_HUM_CALIB_HIGH)
      calib[idx] = {16'b0, value[31:0]};
    @(posedge clk);
  endtask

  // A realistic factory calibration, so that most frames land in the
  // interesting part of the formulas instead of wrapping everywhere.
  task automatic load_typical_calib();
    write_reg(REG_TEMP_CALIB, {16'hFC18, 16'd26435, 16'd27504});
    write_reg(REG_PRESS_CALIB_LOW, {16'd3024, 16'hD643, 16'd36477});
    write_reg(REG_PRESS_CALIB_MID, {16'hFFF9, 16'd140, 16'd2855});
    write_reg(REG_PRESS_CALIB_HIGH, {16'hC6F8, 16'd15500, 16'd6000} &
                                    48'hFFFF_FFFF_FFFF);
    write_reg(REG_HUM_CALIB_LOW, {16'hABCD, 8'd0, 16'd362, 8'd75});
    write_reg(REG_HUM_CALIB_HIGH, {16'h0, 8'd30, 12'd50, 12'd313});
  endtask

  // Typical values with random variation, or fully random registers.
  task automatic load_random_calib();
    logic [47:0] value;
    if ($urandom_range(99) < 60) begin
      load_typical_calib();
      value = calib[REG_TEMP_CALIB];
      value[47:32] = 16'($urandom_range(0, 4000)) - 16'd2000;
      value[15:0] = 16'd27504 + 16'($urandom_range(0, 4000)) - 16'd2000;
      write_reg(REG_TEMP_CALIB, value);
      value = calib[REG_PRESS_CALIB_HIGH];
      value[47:32] = 16'($urandom);
      write_reg(REG_PRESS_CALIB_HIGH, value);
      write_reg(REG_HUM_CALIB_HIGH, {16'($urandom), $urandom});
    end else begin
      for (int i = 0; i < 6; i++)
        write_reg(3'(i), {16'($urandom), $urandom});
    end
  endtask

  // Raw frame near room conditions most of the time, anything otherwise.
  task automatic send_random_frame();
    if ($urandom_range(99) < 70)
      send_frame(20'd519888 + 20'($urandom_range(0, 200000)) - 20'd100000,
                 20'd415148 + 20'($urandom_range(0, 300000)) - 20'd150000,
                 16'($urandom_range(20000, 40000)));
    else
      send_frame(20'($urandom), 20'($urandom), 16'($urandom));
  endtask

  // After reset every register is zero, so P1 is zero and the divisor too.
  task automatic test_reset_values();
    send_frame(20'd0, 20'd0, 16'd0);
    send_frame(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    wait_idle();
  endtask

  // Field extremes under a realistic calibration.
  task automatic test_field_extremes();
    load_typical_calib();
    send_frame(20'd0, 20'd0, 16'd0);
    send_frame(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    send_frame(20'd0, 20'hFFFFF, 16'hFFFF);
    send_frame(20'hFFFFF, 20'd0, 16'd0);
    send_frame(20'd519888, 20'd415148, 16'd0);
    send_frame(20'd519888, 20'd415148, 16'hFFFF);
    send_frame(20'hAAAAA, 20'h55555, 16'hAAAA);
    send_frame(20'h55555, 20'hAAAAA, 16'h5555);
    wait_idle();
  endtask

  // Calibration extremes, including writes to indexes beyond the list.
  task automatic test_calib_extremes();
    for (int i = 0; i < 6; i++) write_reg(3'(i), '1);
    send_frame(20'd519888, 20'd415148, 16'd30000);
    send_frame(20'hFFFFF, 20'd0, 16'hFFFF);
    wait_idle();
    for (int i = 0; i < 6; i++) write_reg(3'(i), 48'h8000_8000_8000);
    send_frame(20'd0, 20'hFFFFF, 16'd0);
    send_frame(20'd519888, 20'd415148, 16'd30000);
    wait_idle();
    load_typical_calib();
    // Zero P1 alone forces the zero divisor while the other paths still run.
    write_reg(REG_PRESS_CALIB_LOW, {16'd3024, 16'hD643, 16'd0});
    write_reg(3'd6, '1);
    write_reg(3'd7, '1);
    send_frame(20'd519888, 20'd415148, 16'd30000);
    send_frame(20'd400000, 20'd300000, 16'd50000);
    wait_idle();
  endtask

  // The receiver holds off long enough that the queue fills and in_ready
  // drops while the sender keeps offering frames.
  task automatic test_back_pressure();
    load_typical_calib();
    hold_len = 3000;
    repeat (8) send_random_frame();
    wait_idle();
  endtask

  task automatic test_random_frames(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        wait_idle();
        load_random_calib();
      end
      send_random_frame();
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 6; i++) calib[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 14;
    recv_idle_pct = 65;
    test_reset_values();
    test_field_extremes();
    test_calib_extremes();
    test_back_pressure();
    test_random_frames(200);

    send_idle_pct = 65;
    recv_idle_pct = 14;
    test_random_frames(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(220);

    repeat (300) @(posedge clk);
    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
rtl/esc_pkg.sv
rtl/esc_queue.sv
rtl/esc_engine.sv
rtl/environmental_sensor_compensation.sv
sim/tb_environmental_sensor_compensation.sv
